/* design/sorted_multiset_nearest_distance_defines.svh */
// Assertion macros shared by the design files of the sorted multiset block.
`ifndef SORTED_MULTISET_NEAREST_DISTANCE_DEFINES_SVH
`define SORTED_MULTISET_NEAREST_DISTANCE_DEFINES_SVH

// Asserts that a property holds at each rising clock edge outside reset.
`define SMND_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define SMND_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* design/smnd_pkg.sv */
// Package with operation and status codes, the controller command type and the status flag type.
package smnd_pkg;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic [1:0] op;
    } cmd_t;

    typedef struct packed {
        logic       empty;
        logic       full;
    } stat_t;

endpackage

/* design/smnd_datapath.sv */
// Datapath: a chain of sorted cells that compare and shift in parallel.
`include "sorted_multiset_nearest_distance_defines.svh"
module smnd_datapath #(
    parameter int CAPACITY = 64,
    parameter int CW = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  smnd_pkg::cmd_t     cmd,
    input  logic [31:0]        in_value,
    output logic [31:0]        res_distance,
    output logic [1:0]         res_status
);

    logic [31:0]   cell_reg [CAPACITY];
    logic [31:0]   cell_next [CAPACITY];
    logic [31:0]   value_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    smnd_pkg::stat_t stat;
    logic [CAPACITY-1:0] live;
    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] le;
    logic [CAPACITY-1:0] le_last;
    logic [CAPACITY-1:0] gt_first;
    logic [CAPACITY-1:0] ins_at;
    logic [CAPACITY-1:0] eq;
    logic [CAPACITY-1:0] before_eq;
    logic [31:0]   lo_dist;
    logic [31:0]   hi_dist;
    logic          has_lo;
    logic          has_hi;
    logic [31:0]   dist_next;
    logic [1:0]    status_next;
    logic          found;
    logic [31:0]   key_v;
    logic          full_insert;
    logic          empty_remove;

    assign key_v = value_reg ^ 32'h8000_0000;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(CAPACITY));

    // The live cells not above the key form a prefix and the cells above it
    // form the rest of the live cells.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            live[i] = (CW'(i) < count_reg);
            gt[i] = live[i] && ((cell_reg[i] ^ 32'h8000_0000) > key_v);
            eq[i] = live[i] && (cell_reg[i] == value_reg);
            le[i] = live[i] && !gt[i];
        end
        before_eq[0] = 1'b0;
        for (int i = 1; i < CAPACITY; i++) before_eq[i] = before_eq[i-1] | eq[i-1];
        le_last[CAPACITY-1] = le[CAPACITY-1];
        for (int i = 0; i < CAPACITY - 1; i++) le_last[i] = le[i] && !le[i+1];
        gt_first[0] = gt[0];
        ins_at[0] = !le[0];
        for (int i = 1; i < CAPACITY; i++) begin
            gt_first[i] = gt[i] && !gt[i-1];
            ins_at[i] = le[i-1] && !le[i];
        end
    end

    // The nearest stored value is the greatest one not above the key or the
    // least one above it.
    always_comb begin
        has_lo = le[0];
        has_hi = |gt;
        lo_dist = '0;
        hi_dist = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            lo_dist = lo_dist | ({32{le_last[i]}} & (value_reg - cell_reg[i]));
            hi_dist = hi_dist | ({32{gt_first[i]}} & (cell_reg[i] - value_reg));
        end
        found = |eq;
    end

    always_comb begin
        count_next = count_reg;
        dist_next = '0;
        status_next = smnd_pkg::ST_OK;
        for (int i = 0; i < CAPACITY; i++) cell_next[i] = cell_reg[i];
        case (cmd.op)
            smnd_pkg::OP_QUERY: begin
                if (stat.empty) status_next = smnd_pkg::ST_EMPTY;
                else if (!has_hi) dist_next = lo_dist;
                else if (!has_lo) dist_next = hi_dist;
                else dist_next = (lo_dist < hi_dist) ? lo_dist : hi_dist;
            end
            smnd_pkg::OP_INSERT: begin
                if (stat.full) status_next = smnd_pkg::ST_FULL;
                else begin
                    count_next = count_reg + CW'(1);
                    if (ins_at[0]) cell_next[0] = value_reg;
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (ins_at[i]) cell_next[i] = value_reg;
                        else if (!le[i]) cell_next[i] = cell_reg[i-1];
                    end
                end
            end
            smnd_pkg::OP_REMOVE: begin
                if (!found) status_next = smnd_pkg::ST_ABSENT;
                else begin
                    count_next = count_reg - CW'(1);
                    for (int i = 0; i < CAPACITY - 1; i++)
                        if (eq[i] || before_eq[i]) cell_next[i] = cell_reg[i+1];
                end
            end
            default: begin
                status_next = smnd_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) value_reg <= in_value;
        if (cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) cell_reg[i] <= cell_next[i];
            res_distance <= dist_next;
            res_status <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    assign full_insert  = cmd.exec && stat.full && (cmd.op == smnd_pkg::OP_INSERT);
    assign empty_remove = cmd.exec && stat.empty && (cmd.op == smnd_pkg::OP_REMOVE);

    `SMND_ASSERT(a_count_range, aclk, aresetn, count_reg <= CW'(CAPACITY), "count over capacity")
    `SMND_ASSERT_NEXT(a_full_hold, aclk, aresetn, full_insert, stat.full, "full insert moved")
    `SMND_ASSERT_NEXT(a_empty_hold, aclk, aresetn, empty_remove, stat.empty, "empty remove moved")

endmodule

/* design/smnd_ctrl.sv */
// Controller: accepts a transaction, runs one execute cycle, holds the result.
`include "sorted_multiset_nearest_distance_defines.svh"
module smnd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     s_op,
    output logic           m_tvalid,
    input  logic           m_tready,
    output smnd_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] op_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.op   = op_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) op_reg <= s_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SMND_ASSERT_NEXT(a_load_exec, aclk, aresetn, cmd.load, cmd.exec, "load without execute")
    `SMND_ASSERT_NEXT(a_exec_out, aclk, aresetn, cmd.exec, m_tvalid, "execute without result")
    `SMND_ASSERT(a_excl, aclk, aresetn, !(s_tready && m_tvalid), "accept while result pending")

endmodule

/* design/sorted_multiset_nearest_distance.sv */
// Top level of the sorted multiset with nearest-distance query.
// Channel | Direction | tdata (low bit up)                | tuser
// s_      | in        | value[31:0]                       | op[1:0]
// m_      | out       | distance[31:0]                    | status[1:0]
// Each transaction passes through accept, one execute cycle of the cell chain,
// and presentation of the result.
// The execute cycle compares all cells at once and shifts them in parallel.
// Reset clears the entry count; stored cells are undefined until written.
// A stalled result holds the block until m_tready rises.
module sorted_multiset_nearest_distance #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value[31:0]
    input  logic [1:0]  s_tuser,  // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // distance[31:0]
    output logic [1:0]  m_tuser   // status[1:0]
);

    smnd_pkg::cmd_t  cmd;

    smnd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    smnd_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_value     (s_tdata),
        .res_distance (m_tdata),
        .res_status   (m_tuser)
    );

endmodule

/* bench/sorted_multiset_nearest_distance_tb.sv */
// Testbench for the sorted multiset block: random and directed streams with a scoreboard.
`timescale 1ns / 1ps

module sorted_multiset_nearest_distance_tb;

    localparam int CAPACITY  = 64;
    localparam int MAX_CYCLES = 2000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] distance;
        logic [1:0]  status;
    } answer_t;

    class multiset_scoreboard;
        logic signed [31:0] entries[$];
        answer_t            pending[$];
        int                 mismatches;
        int                 checked;

        function int count();
            return entries.size();
        endfunction

        function void note_request(logic [1:0] op, logic signed [31:0] v);
            answer_t a;
            logic [32:0] d;
            logic [32:0] best;
            int pos;
            a.distance = '0;
            a.status   = smnd_pkg::ST_OK;
            case (op)
                smnd_pkg::OP_QUERY: begin
                    if (entries.size() == 0) begin
                        a.status = smnd_pkg::ST_EMPTY;
                    end else begin
                        best = {1'b1, 32'd0};
                        foreach (entries[i]) begin
                            if (v >= entries[i])
                                d = {v[31], v} - {entries[i][31], entries[i]};
                            else
                                d = {entries[i][31], entries[i]} - {v[31], v};
                            if (d < best) best = d;
                        end
                        a.distance = best[31:0];
                    end
                end
                smnd_pkg::OP_INSERT: begin
                    if (entries.size() >= CAPACITY) begin
                        a.status = smnd_pkg::ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < entries.size() && entries[pos] <= v) pos++;
                        entries.insert(pos, v);
                    end
                end
                smnd_pkg::OP_REMOVE: begin
                    pos = 0;
                    while (pos < entries.size() && entries[pos] != v) pos++;
                    if (pos >= entries.size()) a.status = smnd_pkg::ST_ABSENT;
                    else entries.delete(pos);
                end
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        function void check_result(logic [31:0] distance, logic [1:0] status);
            answer_t a;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: distance %0d status %0d", distance, status);
                return;
            end
            a = pending.pop_front();
            if (a.distance !== distance || a.status !== status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d wrong: expected distance %0d status %0d, got %0d %0d",
                             checked, a.distance, a.status, distance, status);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    multiset_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  cycle_count;
    int  sent_count;
    logic signed [31:0] recent[$];

    sorted_multiset_nearest_distance #(.CAPACITY(CAPACITY)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Receiver: stalls at random, or holds off entirely for a requested stretch.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        if (aresetn && s_tvalid && s_tready) board.note_request(s_tuser, s_tdata);
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        if (op == smnd_pkg::OP_INSERT) begin
            recent.push_back(v);
            if (recent.size() > 32) void'(recent.pop_front());
        end
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 4 && recent.size() != 0) return recent[$urandom_range(recent.size() - 1)];
        if (r < 7) return $signed($urandom_range(200)) - 100;
        if (r == 7) return ($urandom_range(1)) ? 32'h7fff_ffff - $urandom_range(3)
                                                : 32'h8000_0000 + $urandom_range(3);
        return $urandom;
    endfunction

    // Random phase; insert_bias steers the set toward full or empty.
    task automatic random_phase(int items, int insert_bias);
        int r;
        logic [1:0] op;
        repeat (items) begin
            r = $urandom_range(99);
            if (r < insert_bias) op = smnd_pkg::OP_INSERT;
            else if (r < insert_bias + 30) op = smnd_pkg::OP_QUERY;
            else if (r < 97) op = smnd_pkg::OP_REMOVE;
            else op = OP_UNUSED;
            send_item(op, pick_value());
        end
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = smnd_pkg::OP_QUERY;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        cycle_count = 0;
        sent_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty set, extremes, duplicates, absent removal, unused op.
        send_item(smnd_pkg::OP_QUERY, 32'd5);
        send_item(smnd_pkg::OP_REMOVE, 32'd5);
        send_item(smnd_pkg::OP_INSERT, 32'h8000_0000);
        send_item(smnd_pkg::OP_QUERY, 32'h7fff_ffff);
        send_item(smnd_pkg::OP_INSERT, 32'h7fff_ffff);
        send_item(smnd_pkg::OP_QUERY, 32'h0000_0000);
        send_item(smnd_pkg::OP_QUERY, 32'h8000_0000);
        send_item(smnd_pkg::OP_INSERT, 32'd7);
        send_item(smnd_pkg::OP_INSERT, 32'd7);
        send_item(smnd_pkg::OP_QUERY, 32'd7);
        send_item(smnd_pkg::OP_REMOVE, 32'd7);
        send_item(smnd_pkg::OP_QUERY, 32'd9);
        send_item(smnd_pkg::OP_REMOVE, 32'd8);
        send_item(OP_UNUSED, 32'hffff_ffff);
        send_item(smnd_pkg::OP_QUERY, 32'hffff_ffff);
        send_item(smnd_pkg::OP_REMOVE, 32'h8000_0000);
        send_item(smnd_pkg::OP_REMOVE, 32'h7fff_ffff);
        send_item(smnd_pkg::OP_REMOVE, 32'd7);
        send_item(smnd_pkg::OP_QUERY, 32'hffff_ffff);
        drain();

        random_phase(300, 60);
        // Fill to capacity and push past it.
        while (board.count() < CAPACITY) send_item(smnd_pkg::OP_INSERT, $urandom);
        send_item(smnd_pkg::OP_INSERT, 32'h5555_aaaa);
        send_item(smnd_pkg::OP_QUERY, $urandom);

        send_idle_pct = 77;
        random_phase(250, 35);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 77;
        random_phase(250, 50);

        send_idle_pct = 21;
        recv_stall_pct = 21;
        random_phase(250, 40);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 300;
        random_phase(120, 45);
        drain();
        random_phase(100, 20);
        drain();

        $display("Sent %0d transactions across idle, stall and hold-off phases,", sent_count);
        $display("covering empty, full, duplicate and absent cases; %0d results checked.",
                 board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* sorted_multiset_nearest_distance.f */
+incdir+design
design/smnd_pkg.sv
design/smnd_datapath.sv
design/smnd_ctrl.sv
design/sorted_multiset_nearest_distance.sv
bench/sorted_multiset_nearest_distance_tb.sv
